@@ rtl/reversed_radix_digit_parser_macros.svh @@
// Assertion macros for the reversed radix digit parser.
`ifndef REVERSED_RADIX_DIGIT_PARSER_MACROS_SVH
`define REVERSED_RADIX_DIGIT_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrdp assertion failed");

// Next-cycle implication, disabled during reset.
`define RRDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrdp assertion failed");

`endif

@@ rtl/rrdp_pkg.sv @@
// Shared types and constants for the reversed radix digit parser.
package rrdp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int DIGIT_W = 5;
   localparam int RADIX_W = 4;

   localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE     = 8'd57;
   localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UPPER_J  = 8'd74;
   localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CH_LOWER_J  = 8'd106;
   localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'd55;
   localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd87;

   localparam logic [DIGIT_W-1:0] LETTER_BASE = 5'd20;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;

   typedef enum logic [0:0] {
      CSR_RADIX       = 1'b0,
      CSR_LETTER_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               is_space;
      logic               is_newline;
      logic               legal;
      logic [DIGIT_W-1:0] digit;
      logic [DIGIT_W-1:0] base;
   } decode_type;

   typedef struct packed {
      logic               emit;
      logic               ok;
      logic [VALUE_W-1:0] value;
   } result_type;

endpackage

@@ rtl/rrdp_req_if.sv @@
// Input channel: one character per transaction.
interface rrdp_req_if;
   logic                          valid;
   logic                          ready;
   logic [rrdp_pkg::CHAR_W-1:0]   character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

@@ rtl/rrdp_rsp_if.sv @@
// Result channel: parsed value and legality flag.
interface rrdp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rrdp_pkg::VALUE_W-1:0] value;
   logic                               valid_res;

   modport source (output valid, output value, output valid_res, input ready);
   modport sink   (input valid, input value, input valid_res, output ready);
endinterface

@@ rtl/reversed_radix_digit_parser.sv @@
// A newline waits in stage 1; its result is registered when stage 1 advances.
// Throughput: one character per cycle unless stalled by an untaken result.
// req.ready drops only while the result register holds an untaken result.
// Reset: synchronous, active high; clears the number state and both pipeline
// stages, and returns radix to 10 and letter mode to off.
`include "reversed_radix_digit_parser_macros.svh"

module reversed_radix_digit_parser (
   input  logic                          clock,
   input  logic                          reset,
   rrdp_req_if.sink                      req,
   rrdp_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [rrdp_pkg::RADIX_W-1:0]  csr_data
);

   logic [rrdp_pkg::RADIX_W-1:0] radix_ff;
   logic                         letter_mode_ff;

   logic                         s1_valid_ff, s1_valid_in;
   logic [rrdp_pkg::CHAR_W-1:0]  s1_char_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rrdp_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                         rsp_ok_ff;

   logic                         advance;
   rrdp_pkg::decode_type         dec;
   rrdp_pkg::result_type         res;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= rrdp_pkg::RADIX_RESET;
         letter_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            rrdp_pkg::CSR_RADIX:       radix_ff       <= csr_data;
            rrdp_pkg::CSR_LETTER_MODE: letter_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Stage 1 moves on whenever the result register can take its result.
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || advance;
   assign s1_valid_in = req.valid ? 1'b1 : (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_char_ff <= req.character;
      end
   end

   rrdp_decode u_decode (
      .character   (s1_char_ff),
      .radix       (radix_ff),
      .letter_mode (letter_mode_ff),
      .dec         (dec)
   );

   rrdp_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .dec   (dec),
      .res   (res)
   );

   // Result register
   assign rsp_valid_in = advance ? res.emit : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.emit) begin
         rsp_value_ff <= res.value;
         rsp_ok_ff    <= res.ok;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.value     = $signed(rsp_value_ff);
   assign rsp.valid_res = rsp_ok_ff;

   // A held character must never be overwritten by a new transaction.
   `RRDP_ASSERT_IMPL(a_no_overwrite, clock, reset, s1_valid_ff && !advance, !req.ready)
   // A new result only appears after stage 1 handed over a newline.
   `RRDP_ASSERT_IMPL(a_rsp_from_advance, clock, reset, $rose(rsp_valid_ff), $past(advance))
   // An emitted result reaches the result register on the next edge.
   `RRDP_ASSERT_NEXT(a_emit_lands, clock, reset, advance && res.emit, rsp_valid_ff)

endmodule

@@ rtl/rrdp_decode.sv @@
// Character classifier and digit decoder for the current mode.
module rrdp_decode (
   input  logic [rrdp_pkg::CHAR_W-1:0]  character,
   input  logic [rrdp_pkg::RADIX_W-1:0] radix,
   input  logic                         letter_mode,
   output rrdp_pkg::decode_type         dec
);

   logic [rrdp_pkg::RADIX_W-1:0] base_clamped;
   logic [rrdp_pkg::CHAR_W-1:0]  digit_limit;

   always_comb begin
      if (radix < rrdp_pkg::RADIX_MIN) begin
         base_clamped = rrdp_pkg::RADIX_MIN;
      end else if (radix > rrdp_pkg::RADIX_MAX) begin
         base_clamped = rrdp_pkg::RADIX_MAX;
      end else begin
         base_clamped = radix;
      end
      digit_limit = rrdp_pkg::CH_ZERO + {4'd0, base_clamped};
   end

   always_comb begin
      dec            = '0;
      dec.is_space   = (character == rrdp_pkg::CH_SPACE) ||
                       ((character >= rrdp_pkg::CH_TAB) && (character <= rrdp_pkg::CH_CR));
      dec.is_newline = (character == rrdp_pkg::CH_NEWLINE);
      if (letter_mode) begin
         dec.base = rrdp_pkg::LETTER_BASE;
         if ((character >= rrdp_pkg::CH_ZERO) && (character <= rrdp_pkg::CH_NINE)) begin
            dec.legal = 1'b1;
            dec.digit = 5'(character - rrdp_pkg::CH_ZERO);
         end else if ((character >= rrdp_pkg::CH_UPPER_A) &&
                      (character <= rrdp_pkg::CH_UPPER_J)) begin
            dec.legal = 1'b1;
            dec.digit = 5'(character - rrdp_pkg::UPPER_OFFSET);
         end else if ((character >= rrdp_pkg::CH_LOWER_A) &&
                      (character <= rrdp_pkg::CH_LOWER_J)) begin
            dec.legal = 1'b1;
            dec.digit = 5'(character - rrdp_pkg::LOWER_OFFSET);
         end
      end else begin
         dec.base = {1'b0, base_clamped};
         if ((character >= rrdp_pkg::CH_ZERO) && (character < digit_limit)) begin
            dec.legal = 1'b1;
            dec.digit = 5'(character - rrdp_pkg::CH_ZERO);
         end
      end
   end

endmodule

@@ rtl/rrdp_accum.sv @@
// Number state: accumulator, place weight, error and start flags.
module rrdp_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  rrdp_pkg::decode_type dec,
   output rrdp_pkg::result_type res
);

   logic [rrdp_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [rrdp_pkg::VALUE_W-1:0] weight_ff, weight_in;
   logic                         err_ff, err_in;
   logic                         started_ff, started_in;
   logic [rrdp_pkg::VALUE_W-1:0] term;
   logic [rrdp_pkg::VALUE_W-1:0] weight_next;

   // Both products are 5 x 32, low word kept.
   assign term        = weight_ff * {27'd0, dec.digit};
   assign weight_next = weight_ff * {27'd0, dec.base};

   always_comb begin
      acc_in     = acc_ff;
      weight_in  = weight_ff;
      err_in     = err_ff;
      started_in = started_ff;
      res.emit   = 1'b0;
      res.ok     = ~err_ff;
      res.value  = acc_ff;
      if (!started_ff && dec.is_space) begin
         // leading whitespace, newline included, is dropped
      end else if (dec.is_newline) begin
         res.emit   = 1'b1;
         acc_in     = '0;
         weight_in  = {{(rrdp_pkg::VALUE_W-1){1'b0}}, 1'b1};
         err_in     = 1'b0;
         started_in = 1'b0;
      end else if (dec.legal) begin
         acc_in     = acc_ff + term;
         weight_in  = weight_next;
         started_in = 1'b1;
      end else begin
         err_in     = 1'b1;
         started_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         weight_ff  <= {{(rrdp_pkg::VALUE_W-1){1'b0}}, 1'b1};
         err_ff     <= 1'b0;
         started_ff <= 1'b0;
      end else if (step) begin
         acc_ff     <= acc_in;
         weight_ff  <= weight_in;
         err_ff     <= err_in;
         started_ff <= started_in;
      end
   end

endmodule
